@@ hdl/olam_pkg.sv @@
// Package with operation codes, status codes and cell control type for the ordered list.
package olam_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int OCC_W = 5;

  typedef struct packed {
    logic append;
    logic remove;
    logic rotate;
  } cell_ctl_t;

endpackage

@@ hdl/ordered_list_append_remove_match.sv @@
// Top level of the bounded ordered list built as a chain of slot cells.
// Append and remove each give a single registered result in the cycle after acceptance.
// A list request holds busy while it emits its entries, one entry per cycle, by
// rotating the chain toward the head; entries pass the listing flag and output registers.
// An empty list gives one result in the next cycle. Reset clears the fill count and the
// sequencer; slot contents stay undefined until written. The receiver cannot stall.
module ordered_list_append_remove_match #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic signed [DATA_WIDTH-1:0] out_entry,
  output logic                         out_last,
  output logic [olam_pkg::OCC_W-1:0]   out_occupancy
);
  import olam_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                         hit [DEPTH+1];
  cell_ctl_t                    ctl;

  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic                         listing_r, listing_nxt;
  logic                         valid_r, valid_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic signed [DATA_WIDTH-1:0] entry_r, entry_nxt;
  logic                         last_r, last_nxt;
  logic [OCC_W-1:0]             occ_r, occ_nxt;
  logic [CW+OCC_W-1:0]          occ_ext;
  logic                         list_end;

  assign hit[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] nbr;
      if (g < DEPTH - 1) begin : g_mid
        assign nbr = cell_data[g+1];
      end else begin : g_end
        assign nbr = cell_data[g];
      end
      olam_cell #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX        (g)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_r),
        .value     (in_value),
        .next_data (nbr),
        .wrap_data (cell_data[0]),
        .hit_in    (hit[g]),
        .data      (cell_data[g]),
        .hit_out   (hit[g+1])
      );
    end
  endgenerate

  assign list_end = (idx_r + CW'(1)) == count_r;
  assign occ_ext  = {{OCC_W{1'b0}}, count_nxt};
  assign occ_nxt  = occ_ext[OCC_W-1:0];

  always_comb begin
    ctl         = '0;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    listing_nxt = listing_r;
    valid_nxt   = 1'b0;
    status_nxt  = status_r;
    entry_nxt   = entry_r;
    last_nxt    = last_r;
    if (listing_r) begin
      ctl.rotate = 1'b1;
      valid_nxt  = 1'b1;
      status_nxt = ST_OK;
      entry_nxt  = cell_data[0];
      last_nxt   = list_end;
      idx_nxt    = idx_r + CW'(1);
      if (list_end) begin
        listing_nxt = 1'b0;
      end
    end else if (start) begin
      unique case (in_op)
        OP_APPEND: begin
          valid_nxt = 1'b1;
          last_nxt  = 1'b1;
          entry_nxt = in_value;
          if (count_r == CW'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.append = 1'b1;
            count_nxt  = count_r + CW'(1);
            status_nxt = ST_OK;
          end
        end
        OP_REMOVE: begin
          valid_nxt = 1'b1;
          last_nxt  = 1'b1;
          entry_nxt = in_value;
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (hit[DEPTH]) begin
            ctl.remove = 1'b1;
            count_nxt  = count_r - CW'(1);
            status_nxt = ST_OK;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        OP_LIST: begin
          if (count_r == '0) begin
            valid_nxt  = 1'b1;
            last_nxt   = 1'b1;
            entry_nxt  = '0;
            status_nxt = ST_EMPTY;
          end else begin
            listing_nxt = 1'b1;
            idx_nxt     = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      listing_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      listing_r <= listing_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
    last_r   <= last_nxt;
    occ_r    <= occ_nxt;
  end

  assign busy          = listing_r;
  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_entry     = entry_r;
  assign out_last      = last_r;
  assign out_occupancy = occ_r;

endmodule

@@ hdl/olam_cell.sv @@
// One slot of the list chain: holds a word, matches it, and loads, shifts or rotates.
module olam_cell #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  olam_pkg::cell_ctl_t          ctl,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic signed [DATA_WIDTH-1:0] next_data,
  input  logic signed [DATA_WIDTH-1:0] wrap_data,
  input  logic                         hit_in,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic                         hit_out
);
  import olam_pkg::*;

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] POS = CW'(IDX);

  logic signed [DATA_WIDTH-1:0] data_r;
  logic signed [DATA_WIDTH-1:0] data_nxt;
  logic                         in_use;
  logic                         match;

  assign in_use  = POS < count;
  assign match   = in_use && (data_r == value);
  assign hit_out = hit_in | match;
  assign data    = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.append && (POS == count)) begin
      data_nxt = value;
    end else if (ctl.remove && hit_out) begin
      data_nxt = next_data;
    end else if (ctl.rotate) begin
      if ((POS + CW'(1)) == count) begin
        data_nxt = wrap_data;
      end else begin
        data_nxt = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
